### src/dfam_pkg.sv
// dfam_pkg: shared types and constants of the table-filling dfa minimiser
// no dependencies; imported by the controller, datapath and top level
package dfam_pkg;

  localparam int unsigned MAX_STATES  = 16;
  localparam int unsigned MAX_SYMBOLS = 4;
  localparam int unsigned ST_W        = 4;
  localparam int unsigned SYM_W       = 2;
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned SYMC_W      = 3;
  localparam int unsigned TBL_AW      = ST_W + SYM_W;

  localparam logic [2:0] ADDR_STATE_COUNT   = 3'd0;
  localparam logic [2:0] ADDR_ALPHABET_SIZE = 3'd4;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_PASS,
    ST_CHK,
    ST_SWEEP,
    ST_EMIT_SEL,
    ST_EMIT_RD,
    ST_EMIT_WR,
    ST_EMIT_PUSH
  } ctl_state_t;

  typedef struct packed {
    logic init;
    logic pass_start;
    logic pair_next;
    logic k_next;
    logic set_mark;
    logic sweep_start;
    logic sweep_step;
    logic emit_start;
    logic emit_next;
    logic row_start;
    logic field_wr;
    logic push;
  } ctl_cmd_t;

  typedef struct packed {
    logic single_state;
    logic pair_marked;
    logic hit;
    logic k_last;
    logic pair_last;
    logic changed;
    logic j_last;
    logic surv_i;
    logic i_last;
    logic out_free;
  } dp_stat_t;

endpackage

### src/dfam_if.sv
// dfam_if: valid/ready channels for table entries and minimised rows
// depends on dfam_pkg for field widths
interface dfam_in_if;
  import dfam_pkg::*;
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   source_state;
  logic [SYM_W-1:0]  symbol;
  logic [ST_W-1:0]   target_state;
  logic              accepting;
  logic              last;
  modport source (output valid, source_state, symbol, target_state, accepting, last,
                  input ready);
  modport sink   (input valid, source_state, symbol, target_state, accepting, last,
                  output ready);
endinterface

interface dfam_out_if;
  import dfam_pkg::*;
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   min_state;
  logic [ST_W-1:0]   next_on_sym0;
  logic [ST_W-1:0]   next_on_sym1;
  logic [ST_W-1:0]   next_on_sym2;
  logic [ST_W-1:0]   next_on_sym3;
  logic              is_accepting;
  logic [CNT_W-1:0]  min_count;
  logic              final_row;
  modport source (output valid, min_state, next_on_sym0, next_on_sym1, next_on_sym2,
                  next_on_sym3, is_accepting, min_count, final_row, input ready);
  modport sink   (input valid, min_state, next_on_sym0, next_on_sym1, next_on_sym2,
                  next_on_sym3, is_accepting, min_count, final_row, output ready);
endinterface

### src/dfam_ctrl.sv
// dfam_ctrl: sequencing state machine of the minimiser
// depends on dfam_pkg (state enum, command and status structs)
module dfam_ctrl
  import dfam_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_last,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid && in_last) state_next = ST_INIT;
      end
      ST_INIT: begin
        cmd.init = 1'b1;
        if (stat.single_state) begin
          cmd.sweep_start = 1'b1;
          state_next      = ST_SWEEP;
        end else begin
          cmd.pass_start = 1'b1;
          state_next     = ST_PASS;
        end
      end
      ST_PASS, ST_CHK: begin
        // advance when the pair is done: marked already, a symbol distinguishes it, or all symbols tried
        if ((state == ST_PASS && stat.pair_marked) ||
            (state == ST_CHK && (stat.hit || stat.k_last))) begin
          cmd.set_mark = (state == ST_CHK) && stat.hit;
          if (stat.pair_last) begin
            if (stat.changed || cmd.set_mark) begin
              cmd.pass_start = 1'b1;
              state_next     = ST_PASS;
            end else begin
              cmd.sweep_start = 1'b1;
              state_next      = ST_SWEEP;
            end
          end else begin
            cmd.pair_next = 1'b1;
            state_next    = ST_PASS;
          end
        end else if (state == ST_PASS) begin
          state_next = ST_CHK;
        end else begin
          cmd.k_next = 1'b1;
          state_next = ST_PASS;
        end
      end
      ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (stat.j_last) begin
          cmd.emit_start = 1'b1;
          state_next     = ST_EMIT_SEL;
        end
      end
      ST_EMIT_SEL: begin
        if (stat.surv_i) begin
          cmd.row_start = 1'b1;
          state_next    = ST_EMIT_RD;
        end else if (stat.i_last) begin
          state_next = ST_LOAD;
        end else begin
          cmd.emit_next = 1'b1;
        end
      end
      ST_EMIT_RD: state_next = ST_EMIT_WR;
      ST_EMIT_WR: begin
        cmd.field_wr = 1'b1;
        if (stat.k_last) begin
          state_next = ST_EMIT_PUSH;
        end else begin
          cmd.k_next = 1'b1;
          state_next = ST_EMIT_RD;
        end
      end
      ST_EMIT_PUSH: begin
        if (stat.out_free) begin
          cmd.push = 1'b1;
          if (stat.i_last) begin
            state_next = ST_LOAD;
          end else begin
            cmd.emit_next = 1'b1;
            state_next    = ST_EMIT_SEL;
          end
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

endmodule

### src/dfam_dp.sv
// dfam_dp: transition memory, mark matrix, labels and output register
// depends on dfam_pkg and on dfam_out_if for the result channel
module dfam_dp
  import dfam_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [CNT_W-1:0]  n_eff,
  input  logic [SYMC_W-1:0] a_eff,
  input  logic              wr_en,
  input  logic [ST_W-1:0]   wr_src,
  input  logic [SYM_W-1:0]  wr_sym,
  input  logic [ST_W-1:0]   wr_tgt,
  input  logic              wr_acc,
  input  ctl_cmd_t          cmd,
  output dp_stat_t          stat,
  dfam_out_if.source        out_ch
);

  logic [ST_W-1:0]   tbl [MAX_STATES*MAX_SYMBOLS];
  logic [ST_W-1:0]   rda, rdb;
  logic [MAX_STATES-1:0] acc;
  logic [MAX_STATES*MAX_STATES-1:0] marks;
  logic [MAX_STATES*ST_W-1:0] lbl;
  logic [MAX_STATES-1:0] surv;
  logic [ST_W-1:0]   i, j, last_surv;
  logic [SYM_W-1:0]  k;
  logic [CNT_W-1:0]  cnt;
  logic              changed;
  logic [ST_W-1:0]   fld [MAX_SYMBOLS];
  logic [ST_W-1:0]   ta, tb, rep;
  logic              found;
  logic [ST_W-1:0]   n_top;

  function automatic logic [ST_W-1:0] clampt(input logic [ST_W-1:0] t,
                                             input logic [CNT_W-1:0] n);
    logic [ST_W-1:0] r;
    r = ({1'b0, t} < n) ? t : ST_W'(n - CNT_W'(1));
    return r;
  endfunction

  assign n_top = ST_W'(n_eff - CNT_W'(1));

  // transition memory, two read ports for the pair under test
  always_ff @(posedge clk) begin
    if (wr_en) tbl[{wr_src, wr_sym}] <= wr_tgt;
    rda <= tbl[{i, k}];
    rdb <= tbl[{j, k}];
  end

  assign ta = clampt(rda, n_eff);
  assign tb = clampt(rdb, n_eff);

  // smallest unmarked state below j
  always_comb begin
    found = 1'b0;
    rep   = '0;
    for (int p = MAX_STATES - 1; p >= 0; p--) begin
      if (ST_W'(p) < j && !marks[{j, ST_W'(p)}]) begin
        found = 1'b1;
        rep   = ST_W'(p);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) acc[wr_src] <= wr_acc;
    if (cmd.init) begin
      for (int p = 0; p < MAX_STATES; p++)
        for (int q = 0; q < MAX_STATES; q++)
          marks[p*MAX_STATES+q] <= acc[p] ^ acc[q];
    end
    if (cmd.set_mark) begin
      marks[{i, j}] <= 1'b1;
      marks[{j, i}] <= 1'b1;
    end
    if (cmd.pass_start) begin
      i <= '0;
      j <= ST_W'(1);
      k <= '0;
    end
    if (cmd.pair_next) begin
      k <= '0;
      if ({1'b0, j} + CNT_W'(1) < n_eff) begin
        j <= j + ST_W'(1);
      end else begin
        i <= i + ST_W'(1);
        j <= i + ST_W'(2);
      end
    end
    if (cmd.k_next) k <= k + SYM_W'(1);
    if (cmd.sweep_start) begin
      j    <= '0;
      cnt  <= '0;
      surv <= '0;
    end
    if (cmd.sweep_step) begin
      j <= j + ST_W'(1);
      if (!found) begin
        surv[j]           <= 1'b1;
        lbl[j*ST_W +: ST_W] <= ST_W'(cnt);
        cnt               <= cnt + CNT_W'(1);
        last_surv         <= j;
      end else begin
        lbl[j*ST_W +: ST_W] <= lbl[rep*ST_W +: ST_W];
      end
    end
    if (cmd.emit_start) i <= '0;
    if (cmd.emit_next)  i <= i + ST_W'(1);
    if (cmd.row_start) begin
      k <= '0;
      for (int s = 0; s < MAX_SYMBOLS; s++) fld[s] <= '0;
    end
    if (cmd.field_wr) fld[k] <= lbl[ta*ST_W +: ST_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      changed <= 1'b0;
    end else if (cmd.pass_start) begin
      changed <= 1'b0;
    end else if (cmd.set_mark) begin
      changed <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (cmd.push) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_ch.min_state    <= lbl[i*ST_W +: ST_W];
      out_ch.next_on_sym0 <= fld[0];
      out_ch.next_on_sym1 <= fld[1];
      out_ch.next_on_sym2 <= fld[2];
      out_ch.next_on_sym3 <= fld[3];
      out_ch.is_accepting <= acc[i];
      out_ch.min_count    <= cnt;
      out_ch.final_row    <= (i == last_surv);
    end
  end

  always_comb begin
    stat.single_state = (n_eff == CNT_W'(1));
    stat.pair_marked  = marks[{i, j}];
    stat.hit          = marks[{ta, tb}];
    stat.k_last       = ({1'b0, k} == a_eff - SYMC_W'(1));
    stat.pair_last    = ({1'b0, i} + CNT_W'(2) >= n_eff);
    stat.changed      = changed;
    stat.j_last       = (j == n_top);
    stat.surv_i       = surv[i];
    stat.i_last       = (i == n_top);
    stat.out_free     = !out_ch.valid || out_ch.ready;
  end

endmodule

### src/dfa_minimizer_table_filling.sv
// dfa_minimizer_table_filling: top level of the table-filling dfa minimiser
// depends on dfam_pkg, dfam_if, dfam_ctrl and dfam_dp
//
// Table entries are taken one request per cycle while the block is loading; each writes
// one target into a 64-entry transition memory and the source state's accepting flag.
// A request with last set starts minimisation and the input stalls until the last row
// has been handed to the output register. Minimisation runs through a marks matrix held
// in flip-flops: the INIT state seeds it from the accepting flags, then each pass visits
// every state pair, leaving a pair already marked from its PASS state and otherwise going
// through a PASS and a CHK state per symbol tried (the transition memory is read at both
// states of the pair and the registered targets are checked against the matrix). Passes
// repeat until one changes nothing, so the total run time is data dependent. A sweep over
// all states then picks representatives and labels; emission skips each merged state,
// reads and writes one field per symbol of each surviving row and pushes it, waiting while
// the sink stalls. The output is registered, so a row waits there while the next is built.
module dfa_minimizer_table_filling
  import dfam_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  dfam_in_if.sink     in_ch,
  dfam_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CNT_W-1:0]  state_count;
  logic [SYMC_W-1:0] alphabet_size;
  logic [CNT_W-1:0]  n_eff;
  logic [SYMC_W-1:0] a_eff;
  logic              in_ready;
  logic              accept, wr_en;
  ctl_cmd_t          cmd;
  dp_stat_t          stat;

  // configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      state_count   <= CNT_W'(16);
      alphabet_size <= SYMC_W'(2);
    end else if (psel && penable && pwrite) begin
      case (paddr)
        ADDR_STATE_COUNT:   state_count   <= pwdata[CNT_W-1:0];
        ADDR_ALPHABET_SIZE: alphabet_size <= pwdata[SYMC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      ADDR_STATE_COUNT:   prdata = {{(32-CNT_W){1'b0}}, state_count};
      ADDR_ALPHABET_SIZE: prdata = {{(32-SYMC_W){1'b0}}, alphabet_size};
      default:            prdata = '0;
    endcase
  end

  // saturate the registers to the supported ranges
  assign n_eff = (state_count == '0) ? CNT_W'(1) :
                 (state_count > CNT_W'(MAX_STATES)) ? CNT_W'(MAX_STATES) : state_count;
  assign a_eff = (alphabet_size == '0) ? SYMC_W'(1) :
                 (alphabet_size > SYMC_W'(MAX_SYMBOLS)) ? SYMC_W'(MAX_SYMBOLS)
                                                        : alphabet_size;

  // entries naming a state out of range are dropped, last still counts
  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;
  assign wr_en       = accept && ({1'b0, in_ch.source_state} < n_eff) &&
                       ({1'b0, in_ch.target_state} < n_eff);

  dfam_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dfam_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .n_eff  (n_eff),
    .a_eff  (a_eff),
    .wr_en  (wr_en),
    .wr_src (in_ch.source_state),
    .wr_sym (in_ch.symbol),
    .wr_tgt (in_ch.target_state),
    .wr_acc (in_ch.accepting),
    .cmd    (cmd),
    .stat   (stat),
    .out_ch (out_ch)
  );

endmodule
